// ===== rtl/softmax_vector_normalizer_defines.svh =====
// Assertion macros shared by the softmax normalizer RTL.
// Depends on nothing; included by the top level only.
`ifndef SOFTMAX_VECTOR_NORMALIZER_DEFINES_SVH
`define SOFTMAX_VECTOR_NORMALIZER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SVN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SVN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/smx_pkg.sv =====
// Package for the softmax normalizer: widths, exp table, queue entry type.
// Depends on nothing; used by the top level, smx_front and smx_back through scoped names.
package smx_pkg;
    localparam int MaxLenDefault = 16;
    localparam int ScoreW = 16;
    localparam int ExpW = 17;
    localparam int ProbW = 16;
    localparam int IdxOutW = 4;
    localparam logic [16:0] Log2eQ16 = 17'd94548;

    typedef struct packed {
        logic [ScoreW-1:0] score;
        logic              last;
    } smx_entry_t;

    function automatic logic [16:0] pow2_neg(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0: r = 17'd65536;
            5'd1: r = 17'd62757;
            5'd2: r = 17'd60097;
            5'd3: r = 17'd57549;
            5'd4: r = 17'd55109;
            5'd5: r = 17'd52773;
            5'd6: r = 17'd50535;
            5'd7: r = 17'd48393;
            5'd8: r = 17'd46341;
            5'd9: r = 17'd44376;
            5'd10: r = 17'd42495;
            5'd11: r = 17'd40693;
            5'd12: r = 17'd38968;
            5'd13: r = 17'd37316;
            5'd14: r = 17'd35734;
            5'd15: r = 17'd34219;
            5'd16: r = 17'd32768;
            default: r = 17'd0;
        endcase
        return r;
    endfunction
endpackage

// ===== rtl/softmax_vector_normalizer.sv =====
// Softmax over a vector of Q8.8 scores; Q0.16 probabilities out in input order.
// Load: one element per cycle while loading and the output is not stalled.
// Compute: exp per element (read, subtract, multiply, accumulate), then divide per
// element (read, start, wait, emit); new scores load only after the last result.
// rst_n asynchronous, active low: clears count, max, sum, overflow flag and queue.
// Stores hold no reset; only written entries are read.
`include "softmax_vector_normalizer_defines.svh"
module softmax_vector_normalizer
#(
    parameter int MAX_LEN = smx_pkg::MaxLenDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] score
    input  logic        s_axis_tlast,   // end_of_vector
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] probability, [19:16] element_index, rest 0
    output logic        m_axis_tuser,   // [0] dropped
    output logic        m_axis_tlast    // final_result
);
    smx_pkg::smx_entry_t in_entry;
    smx_pkg::smx_entry_t q_entry;
    logic q_valid;
    logic q_ready;
    logic [15:0] probability;
    logic [3:0]  element_index;
    logic dropped;
    logic final_result;
    logic out_stall;

    assign in_entry = {s_axis_tdata, s_axis_tlast};

    // Front: accept transfers into a short queue.
    smx_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_entry (in_entry),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry)
    );

    // Back: store, exp, sum and divide.
    smx_back #(.MAX_LEN(MAX_LEN)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_entry       (q_entry),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .probability   (probability),
        .element_index (element_index),
        .dropped       (dropped),
        .final_result  (final_result)
    );

    assign m_axis_tdata = {4'd0, element_index, probability};
    assign m_axis_tuser = dropped;
    assign m_axis_tlast = final_result;
    assign out_stall    = m_axis_tvalid && !m_axis_tready;

    `SVN_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result dropped")
    `SVN_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "result changed while held")
    `SVN_ASSERT_IMP(a_no_load_while_out, q_valid && q_ready, !out_stall, "load during stall")
endmodule

// ===== rtl/smx_front.sv =====
// Front end: input stream into a two-entry queue of (score, last) entries.
// Depends on smx_pkg.
module smx_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  smx_pkg::smx_entry_t in_entry,
    output logic               q_valid,
    input  logic               q_ready,
    output smx_pkg::smx_entry_t q_entry
);
    smx_pkg::smx_entry_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_entry  = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_entry;
    end
endmodule

// ===== rtl/smx_divider.sv =====
// Restoring divider, one quotient bit per cycle: (num) / den, 37-bit numerator.
// Depends on nothing.
module smx_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [36:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [36:0] quot
);
    logic [36:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [33:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg, q_reg[36]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign quot    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= busy_reg && !start && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd37;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            // Remainder stays below the divisor, so 32 bits hold it.
            if (!trial[33])
            begin
                rem_reg <= trial[31:0];
                q_reg   <= {q_reg[35:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                q_reg   <= {q_reg[35:0], 1'b0};
            end
        end
    end
endmodule

// ===== rtl/smx_back.sv =====
// Back end: store, running max, exp pass, sum, divide pass and result register.
// Depends on smx_pkg and smx_divider.
module smx_back
#(
    parameter int MAX_LEN = smx_pkg::MaxLenDefault
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  smx_pkg::smx_entry_t        q_entry,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [smx_pkg::ProbW-1:0]  probability,
    output logic [smx_pkg::IdxOutW-1:0] element_index,
    output logic                       dropped,
    output logic                       final_result
);
    localparam int IW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = smx_pkg::ExpW + CW;
    localparam int IdxOutW = smx_pkg::IdxOutW;

    typedef enum logic [3:0]
    {
        LOAD, EXP_X, EXP_Y, EXP_Z, EXP_W, DIV_RD, DIV_GO, DIV_WAIT, EMIT
    } st_t;

    st_t st_reg;
    logic [15:0] score_mem [MAX_LEN];
    logic [16:0] exp_mem [MAX_LEN];
    logic [CW-1:0] count_reg;
    logic [IW-1:0] k_reg;
    logic signed [15:0] max_reg;
    logic [SW-1:0] sum_reg;
    logic ovf_reg;
    logic [15:0] rd_score_reg;
    logic [16:0] rd_exp_reg;
    logic [15:0] x_reg;
    logic [32:0] y_reg;
    logic div_start;
    logic div_done;
    logic [36:0] div_quot;
    logic [16:0] tab_a;
    logic [16:0] tab_b;
    logic [28:0] interp;
    logic [16:0] v_lin;
    logic [8:0] n_sh;
    logic [16:0] e_val;
    logic [17:0] e_rnd;

    assign q_ready = (st_reg == LOAD) && !(out_valid && !out_ready);

    // Exp: interpolate table, then round-shift by the integer part.
    always_comb
    begin
        tab_a  = smx_pkg::pow2_neg({1'b0, y_reg[23:20]});
        tab_b  = smx_pkg::pow2_neg({1'b0, y_reg[23:20]} + 5'd1);
        interp = (tab_a - tab_b) * {17'd0, y_reg[19:8]} + 29'd2048;
        v_lin  = tab_a - interp[28:12];
        n_sh   = y_reg[32:24];
        e_rnd  = '0;
        if (n_sh >= 9'd17)
            e_val = '0;
        else if (n_sh == 9'd0)
            e_val = v_lin;
        else
        begin
            e_rnd = ({1'b0, v_lin} + (18'd1 << (n_sh[4:0] - 5'd1))) >> n_sh[4:0];
            e_val = e_rnd[16:0];
        end
    end

    smx_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({4'd0, rd_exp_reg, 16'd0}
                + {{(37-SW+1){1'b0}}, sum_reg[SW-1:1]}),
        .den   ({{(32-SW){1'b0}}, sum_reg}),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign div_start = (st_reg == DIV_GO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= LOAD;
            count_reg     <= '0;
            k_reg         <= '0;
            max_reg       <= 16'sh8000;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid     <= 1'b0;
            probability   <= '0;
            element_index <= '0;
            dropped       <= 1'b0;
            final_result  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready && st_reg != EMIT)
                out_valid <= 1'b0;
            case (st_reg)
                LOAD:
                begin
                    if (q_valid && q_ready)
                    begin
                        if (count_reg < CW'(MAX_LEN))
                        begin
                            count_reg <= count_reg + CW'(1);
                            if ($signed(q_entry.score) > max_reg)
                                max_reg <= $signed(q_entry.score);
                        end
                        else
                            ovf_reg <= 1'b1;
                        if (q_entry.last)
                        begin
                            k_reg   <= '0;
                            sum_reg <= '0;
                            if (count_reg != '0 || count_reg < CW'(MAX_LEN))
                                st_reg <= EXP_X;
                        end
                    end
                end
                // Read, subtract, multiply, then accumulate.
                EXP_X: st_reg <= EXP_Y;
                EXP_Y: st_reg <= EXP_Z;
                EXP_Z: st_reg <= EXP_W;
                EXP_W:
                begin
                    sum_reg <= sum_reg + SW'(e_val);
                    if (CW'(k_reg) + CW'(1) == count_reg)
                    begin
                        k_reg  <= '0;
                        st_reg <= DIV_RD;
                    end
                    else
                    begin
                        k_reg  <= k_reg + IW'(1);
                        st_reg <= EXP_X;
                    end
                end
                // Wait state so the stored exp for k_reg is registered before the divide starts.
                DIV_RD: st_reg <= DIV_GO;
                DIV_GO: st_reg <= DIV_WAIT;
                DIV_WAIT:
                    if (div_done)
                        st_reg <= EMIT;
                EMIT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_valid     <= 1'b1;
                        probability   <= (div_quot > 37'd65535) ? 16'hFFFF : div_quot[15:0];
                        element_index <= IdxOutW'(k_reg);
                        dropped       <= ovf_reg;
                        final_result  <= (CW'(k_reg) + CW'(1) == count_reg);
                        if (CW'(k_reg) + CW'(1) == count_reg)
                        begin
                            st_reg    <= LOAD;
                            count_reg <= '0;
                            max_reg   <= 16'sh8000;
                            ovf_reg   <= 1'b0;
                            k_reg     <= '0;
                        end
                        else
                        begin
                            k_reg  <= k_reg + IW'(1);
                            st_reg <= DIV_RD;
                        end
                    end
                end
                default: st_reg <= LOAD;
            endcase
        end
    end

    // Datapath registers and stores.
    always_ff @(posedge clk)
    begin
        if (st_reg == LOAD && q_valid && q_ready && count_reg < CW'(MAX_LEN))
            score_mem[count_reg[IW-1:0]] <= q_entry.score;
        rd_score_reg <= score_mem[k_reg];
        rd_exp_reg   <= exp_mem[k_reg];
        x_reg        <= 16'(max_reg - $signed(rd_score_reg));
        y_reg        <= {17'd0, x_reg} * {16'd0, smx_pkg::Log2eQ16};
        if (st_reg == EXP_W)
            exp_mem[k_reg] <= e_val;
    end
endmodule

// ===== tb/tb_softmax_vector_normalizer.sv =====
// Self-checking testbench for softmax_vector_normalizer: stream vectors of Q8.8
// scores in, compare every Q0.16 probability against an in-bench fixed-point predictor.
// Depends on the RTL top level only.

class softmax_scoreboard;
    typedef struct {
        logic [15:0] probability;
        logic [3:0]  element_index;
        logic        dropped;
        logic        final_result;
    } prob_t;

    prob_t       pending_probs[$];
    logic [15:0] scores[16];
    int          count;
    int          peak;
    bit          overflowed;
    int          mismatches;
    int          checked;
    int          vectors;

    function new();
        count = 0;
        peak = -32768;
        overflowed = 0;
        mismatches = 0;
        checked = 0;
        vectors = 0;
    endfunction

    function logic [16:0] exp_neg(logic [15:0] x);
        logic [16:0] tab[17];
        longint unsigned y;
        int unsigned n;
        int unsigned f;
        int unsigned a;
        int unsigned b;
        int unsigned v;
        tab = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
        y = longint'(x) * 94548;
        n = 32'(y >> 24);
        f = 32'((y >> 8) & 64'hFFFF);
        a = tab[f >> 12];
        b = tab[(f >> 12) + 1];
        v = a - (((a - b) * (f & 32'hFFF) + 2048) >> 12);
        if (n >= 17)
            return 17'd0;
        if (n == 0)
            return 17'(v);
        return 17'((v + (1 << (n - 1))) >> n);
    endfunction

    // Note one accepted score; on end of vector queue the expected probabilities.
    function void note_score(logic [15:0] score, logic last);
        int unsigned e[16];
        int unsigned total;
        longint unsigned p;
        prob_t r;
        if (count < 16)
        begin
            scores[count] = score;
            count++;
            if ($signed(score) > peak)
                peak = $signed(score);
        end
        else
            overflowed = 1;
        if (!last)
            return;
        total = 0;
        for (int k = 0; k < count; k++)
        begin
            e[k] = exp_neg(16'(peak - $signed(scores[k])));
            total += e[k];
        end
        for (int k = 0; k < count; k++)
        begin
            p = ((longint'(e[k]) << 16) + (total >> 1)) / total;
            r.probability = (p > 65535) ? 16'hFFFF : p[15:0];
            r.element_index = k[3:0];
            r.dropped = overflowed;
            r.final_result = (k + 1 == count);
            pending_probs.push_back(r);
        end
        vectors++;
        count = 0;
        peak = -32768;
        overflowed = 0;
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_prob(logic [15:0] prob, logic [3:0] idx, logic drop, logic fin,
                             logic [3:0] pad);
        prob_t x;
        checked++;
        if (pending_probs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result prob=%0d idx=%0d", prob, idx);
            return;
        end
        x = pending_probs.pop_front();
        if (prob !== x.probability || idx !== x.element_index || drop !== x.dropped
            || fin !== x.final_result || pad !== 4'd0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: exp p=%0d i=%0d d=%0b l=%0b got p=%0d i=%0d d=%0b l=%0b",
                         x.probability, x.element_index, x.dropped, x.final_result,
                         prob, idx, drop, fin);
        end
    endfunction
endclass

module tb_softmax_vector_normalizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // [15:0] score
    logic        s_axis_tlast;     // end_of_vector
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [15:0] probability, [19:16] element_index
    logic        m_axis_tuser;     // [0] dropped
    logic        m_axis_tlast;     // final_result

    softmax_scoreboard sb;
    int  idle_cycles;
    int  scores_sent;
    bit  gaps_on;        // random idling on both sides
    bit  hold_sink;      // long receiver stall requested
    bit  timed_out;

    softmax_vector_normalizer u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Score the handshakes; the watchdog counts edges with no transfer on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_score(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_prob(m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tuser,
                              m_axis_tlast, m_axis_tdata[23:20]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, or a long hold when asked.
    initial
    begin
        int n;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 0;
                repeat (600) @(posedge clk);
                hold_sink = 0;
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 7);
                m_axis_tready <= 0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1;
                @(posedge clk);
            end
        end
    end

    // Offer one score and hold it until it is transferred.
    task automatic send_score(logic [15:0] score, logic last);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= score;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        scores_sent++;
    endtask

    task automatic send_vector(int len, int mode);
        logic [15:0] v;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: v = 16'($urandom);
                1: v = 16'($urandom_range(0, 2047) - 1024);   // close scores
                default: v = (i == 0) ? 16'h7FFF : 16'h8000;
            endcase
            send_score(v, i == len - 1);
        end
    endtask

    // Drop valid and wait until every queued probability has been transferred.
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (sb.pending_probs.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int len;
        sb = new();
        idle_cycles = 0;
        scores_sent = 0;
        gaps_on = 0;
        hold_sink = 0;
        timed_out = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: single elements, extremes, equal scores, a small spread, a full random vector.
        send_score(16'h8000, 1);
        send_score(16'h7FFF, 1);
        send_score(16'h7FFF, 0);
        send_score(16'h8000, 1);
        send_score(16'h0000, 0);
        send_score(16'h0000, 0);
        send_score(16'h0000, 1);
        send_score(16'h0100, 0);
        send_score(16'hFFFF, 1);
        send_vector(16, 0);
        drain();

        gaps_on = 1;
        // Overflowed vector, tlast on a dropped element.
        send_vector(18, 1);
        // Receiver stalls long while more vectors keep coming.
        hold_sink = 1;
        send_vector(16, 0);
        send_vector(16, 2);
        send_vector(5, 1);
        drain();

        while (scores_sent < 290)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                              : $urandom_range(1, 16);
            send_vector(len, $urandom_range(0, 2));
        end
        // Last stretch with no idling.
        gaps_on = 0;
        while (scores_sent < 330)
            send_vector($urandom_range(1, 16), $urandom_range(0, 1));
        drain();
        repeat (200) @(posedge clk);

        $display("Covered %0d scores in %0d vectors, %0d probabilities checked,",
                 scores_sent, sb.vectors, sb.checked);
        $display("including overflowed vectors, extreme scores and a long output stall.");
        if (sb.mismatches == 0 && sb.pending_probs.size() == 0)
            $display("DONE: 0 errors");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_probs.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= WatchdogLimit && !timed_out)
            begin
                timed_out = 1;
                $display("Timeout: no transfer for %0d cycles", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/smx_pkg.sv
rtl/smx_front.sv
rtl/smx_divider.sv
rtl/smx_back.sv
rtl/softmax_vector_normalizer.sv
tb/tb_softmax_vector_normalizer.sv
